[sv/kfs_pkg.sv]
// Package for the keyframe vec3 linear sampler: op codes, state encoding, sizes.
// No dependencies.
`default_nettype none
package kfs_pkg;
	localparam int KfsMaxKeys = 64;
	localparam int TimeW = 32;
	localparam int ValW = 32;
	localparam int FracW = 16;

	typedef enum logic [1:0] {
		OP_CLEAR  = 2'd0,
		OP_APPEND = 2'd1,
		OP_SAMPLE = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SCAN1,
		ST_CHECK,
		ST_SCAN2,
		ST_RDLO,
		ST_RDHI,
		ST_DIV,
		ST_MUL,
		ST_SUM,
		ST_EMITKEY,
		ST_OUT
	} state_t;
endpackage
`default_nettype wire

[sv/kfs_div.sv]
// Restoring divider, one quotient bit per cycle: (num << 16) / den, clamped to Q0.16.
// Uses kfs_pkg.
`default_nettype none
module kfs_div (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [kfs_pkg::TimeW-1:0]   num,
	input  wire logic [kfs_pkg::TimeW-1:0]   den,
	output logic                             done,
	output logic [kfs_pkg::FracW-1:0]        frac
);
	import kfs_pkg::*;
	localparam int NW = TimeW + FracW;
	localparam int CW = $clog2(NW + 1);

	logic [NW-1:0]    quo_q;
	logic [TimeW:0]   rem_q;
	logic [TimeW-1:0] den_q;
	logic [CW-1:0]    cnt_q;
	logic             run_q;
	logic [TimeW:0]   trial;
	logic             take;

	always_comb begin
		trial = {rem_q[TimeW-1:0], quo_q[NW-1]};
		take = trial >= {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CW'(NW);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					run_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= {num, {FracW{1'b0}}};
			rem_q <= '0;
			den_q <= den;
		end else if (run_q) begin
			rem_q <= take ? trial - {1'b0, den_q} : trial;
			quo_q <= {quo_q[NW-2:0], take};
		end
	end

	// a quotient of 2^16 or more saturates to the largest Q0.16 fraction
	assign frac = (|quo_q[NW-1:FracW]) ? {FracW{1'b1}} : quo_q[FracW-1:0];

	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n) start |-> !run_q)
		else $error("divider restarted while busy");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n) done |-> !run_q)
		else $error("done while running");
	a_run_count: assert property (@(posedge clk) disable iff (!arst_n) run_q |-> cnt_q != '0)
		else $error("run with zero count");
endmodule
`default_nettype wire

[sv/keyframe_vec3_linear_sampler.sv]
// Top level of the keyframe vec3 linear sampler: key memories, scan sequencer, blend.
// Uses kfs_pkg and kfs_div.
//
//  channel | direction | signals
//  in      | to block  | in_valid, in_stall, op, time_point, in_x, in_y, in_z
//  out     | from block| out_valid, out_stall, out_x, out_y, out_z, has_keys
//
// Clear and append are done without leaving the idle state. An interpolating sample
// makes two scans of the time memory at one key a cycle, one read each of the bracket
// keys, a run of the serial divider, then multiply and add.
// A sample that returns a stored key skips the divider; an empty table returns zeros.
// Reset empties the table at once; key memories hold no reset.
// A result waits in the output register while out_stall is high; no new item is taken.
`default_nettype none
module keyframe_vec3_linear_sampler #(
	parameter int MAX_KEYS = kfs_pkg::KfsMaxKeys
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_stall,
	input  wire logic [1:0]                          op,
	input  wire logic [kfs_pkg::TimeW-1:0]           time_point,
	input  wire logic signed [kfs_pkg::ValW-1:0]     in_x,
	input  wire logic signed [kfs_pkg::ValW-1:0]     in_y,
	input  wire logic signed [kfs_pkg::ValW-1:0]     in_z,
	output logic                                     out_valid,
	input  wire logic                                out_stall,
	output logic signed [kfs_pkg::ValW-1:0]          out_x,
	output logic signed [kfs_pkg::ValW-1:0]          out_y,
	output logic signed [kfs_pkg::ValW-1:0]          out_z,
	output logic                                     has_keys
);
	import kfs_pkg::*;
	localparam int AW = $clog2(MAX_KEYS);
	localparam int CW = $clog2(MAX_KEYS + 1);

	logic [TimeW-1:0]  tmem [MAX_KEYS];
	logic [3*ValW-1:0] vmem [MAX_KEYS];

	state_t st_q, st_d;
	logic [CW-1:0] count_q;
	logic [CW-1:0] idx_q;
	logic          rd_v_q;
	logic [AW-1:0] rd_a_q;
	logic [TimeW-1:0] t_rd_q;
	logic [3*ValW-1:0] v_rd_q;
	logic [TimeW-1:0] qt_q;
	logic [AW-1:0] first_q, last_q, lo_q, hi_q, emit_q;
	logic [TimeW-1:0] tf_q, tl_q, tlo_q, thi_q;
	logic [3*ValW-1:0] vlo_q, vhi_q;
	logic signed [ValW+FracW:0] prod_q [3];
	logic [FracW-1:0] frac;
	logic div_done;
	logic div_start;
	logic [AW-1:0] rd_addr;
	logic          rd_en;
	logic accept, wr_en;
	logic signed [ValW:0] diff [3];

	assign accept = in_valid && !in_stall;
	assign in_stall = (st_q != ST_IDLE) || out_valid;
	assign wr_en = accept && op == OP_APPEND && count_q < CW'(MAX_KEYS);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			tmem[count_q[AW-1:0]] <= time_point;
			vmem[count_q[AW-1:0]] <= {in_x, in_y, in_z};
		end
		t_rd_q <= tmem[rd_addr];
		v_rd_q <= vmem[rd_addr];
	end

	// address issue
	always_comb begin
		rd_en = 1'b0;
		rd_addr = idx_q[AW-1:0];
		unique case (st_q)
			ST_SCAN1, ST_SCAN2: rd_en = idx_q < count_q;
			ST_RDLO: begin rd_en = 1'b1; rd_addr = lo_q; end
			ST_RDHI: begin rd_en = 1'b1; rd_addr = hi_q; end
			ST_CHECK, ST_EMITKEY: rd_addr = emit_q;
			default: rd_addr = idx_q[AW-1:0];
		endcase
	end

	// lo value lands during RDHI, hi value during the first divide cycle
	assign div_start = st_q == ST_RDHI;

	kfs_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.num(qt_q - tlo_q), .den(thi_q - tlo_q),
		.done(div_done), .frac(frac)
	);

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			ST_IDLE:
				if (accept && op == OP_SAMPLE)
					st_d = (count_q == '0) ? ST_OUT : ST_SCAN1;
			ST_SCAN1: if (!rd_en && !rd_v_q) st_d = ST_CHECK;
			ST_CHECK:
				if (qt_q <= tf_q || qt_q >= tl_q) st_d = ST_EMITKEY;
				else st_d = ST_SCAN2;
			ST_SCAN2: if (!rd_en && !rd_v_q) begin
				st_d = (lo_q == hi_q || tlo_q == thi_q) ? ST_EMITKEY : ST_RDLO;
			end
			ST_RDLO: st_d = ST_RDHI;
			ST_RDHI: st_d = ST_DIV;
			ST_DIV: if (div_done) st_d = ST_MUL;
			ST_MUL: st_d = ST_SUM;
			ST_SUM: st_d = ST_OUT;
			ST_EMITKEY: if (rd_v_q) st_d = ST_OUT;
			ST_OUT: st_d = ST_IDLE;
			default: st_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			count_q <= '0;
			out_valid <= 1'b0;
			rd_v_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (accept && op == OP_CLEAR) count_q <= '0;
			else if (wr_en) count_q <= count_q + 1'b1;
			if (out_valid && !out_stall) out_valid <= 1'b0;
			else if (st_q == ST_OUT) out_valid <= 1'b1;
			rd_v_q <= rd_en || (st_q == ST_EMITKEY && !rd_v_q);
		end
	end

	for (genvar c = 0; c < 3; c++) begin : g_lane
		assign diff[c] = (ValW+1)'($signed(vhi_q[(2-c)*ValW +: ValW]))
			- (ValW+1)'($signed(vlo_q[(2-c)*ValW +: ValW]));
	end

	always_ff @(posedge clk) begin
		rd_a_q <= rd_addr;
		unique case (st_q)
			ST_IDLE: if (accept) begin
				qt_q <= time_point;
				idx_q <= '0;
				first_q <= '0; last_q <= '0;
			end
			ST_SCAN1: begin
				if (rd_en) idx_q <= idx_q + 1'b1;
				if (rd_v_q) begin
					if (rd_a_q == '0) begin
						tf_q <= t_rd_q; tl_q <= t_rd_q;
					end else begin
						if (t_rd_q < tf_q) begin tf_q <= t_rd_q; first_q <= rd_a_q; end
						if (t_rd_q > tl_q) begin tl_q <= t_rd_q; last_q <= rd_a_q; end
					end
				end
			end
			ST_CHECK: begin
				idx_q <= '0;
				emit_q <= (qt_q <= tf_q) ? first_q : last_q;
				lo_q <= first_q; hi_q <= last_q;
				tlo_q <= tf_q; thi_q <= tl_q;
			end
			ST_SCAN2: begin
				if (rd_en) idx_q <= idx_q + 1'b1;
				if (rd_v_q) begin
					if (t_rd_q <= qt_q && t_rd_q >= tlo_q) begin
						lo_q <= rd_a_q; tlo_q <= t_rd_q;
					end
					if (t_rd_q >= qt_q && t_rd_q <= thi_q) begin
						hi_q <= rd_a_q; thi_q <= t_rd_q;
					end
				end
				emit_q <= lo_q;
			end
			ST_RDHI: if (rd_v_q) vlo_q <= v_rd_q;
			ST_DIV: if (rd_v_q) vhi_q <= v_rd_q;
			ST_MUL: for (int c = 0; c < 3; c++)
				prod_q[c] <= $signed(diff[c]) * $signed({1'b0, frac});
			ST_SUM: begin
				for (int c = 0; c < 3; c++) begin
					// truncate toward zero: bias negatives before the shift
					logic signed [ValW+FracW:0] p;
					p = prod_q[c] + (prod_q[c][ValW+FracW] ? (ValW+FracW+1)'(16'hFFFF) : '0);
					case (c)
						0: out_x <= vlo_q[2*ValW +: ValW] + p[FracW +: ValW];
						1: out_y <= vlo_q[ValW +: ValW] + p[FracW +: ValW];
						default: out_z <= vlo_q[0 +: ValW] + p[FracW +: ValW];
					endcase
				end
				has_keys <= 1'b1;
			end
			ST_EMITKEY: if (rd_v_q) begin
				{out_x, out_y, out_z} <= v_rd_q;
				has_keys <= 1'b1;
			end
			ST_OUT: if (count_q == '0) begin
				out_x <= '0; out_y <= '0; out_z <= '0; has_keys <= 1'b0;
			end
			default: ;
		endcase
	end

	a_count: assert property (@(posedge clk) disable iff (!arst_n) count_q <= CW'(MAX_KEYS))
		else $error("key count overflow");
	a_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> st_q == ST_IDLE && !out_valid)
		else $error("accept busy");
	a_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_OUT |-> !out_valid)
		else $error("result overrun");
	a_write: assert property (@(posedge clk) disable iff (!arst_n) wr_en |-> st_q == ST_IDLE)
		else $error("write during sample");
endmodule
`default_nettype wire
